### sv/lcar_pkg.sv
package lcar_pkg;

  // Field and register widths.
  localparam int RAW_W      = 24;
  localparam int WEIGHT_W   = 16;
  localparam int FACTOR_W   = 32;
  localparam int FRAC_BITS  = 16;
  localparam int SUM_W      = 32;
  localparam int COUNT_W    = 8;
  localparam int TIMEOUT_W  = 15;
  localparam int GAP_W      = 20;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;
  localparam int DIFF_W     = RAW_W + 1;
  localparam int PROD_W     = DIFF_W + FACTOR_W;

  // Operation codes carried by each tick.
  typedef logic [1:0] opcode_t;
  localparam opcode_t OP_NONE  = 2'd0;
  localparam opcode_t OP_WEIGH = 2'd1;
  localparam opcode_t OP_TARE  = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_FACTOR = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_AVERAGE_COUNT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_TICKS = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_GAP_TICKS     = 2'd3;

  // Register values after reset (factor is 1000.0 in Q16.16).
  localparam logic signed [FACTOR_W-1:0] WEIGHT_FACTOR_RST = 32'sd65536000;
  localparam logic [COUNT_W-1:0]         AVERAGE_COUNT_RST = 8'd10;
  localparam logic [TIMEOUT_W-1:0]       TIMEOUT_TICKS_RST = 15'd1000;
  localparam logic [GAP_W-1:0]           GAP_TICKS_RST     = 20'd10000;

  // Converter protocol phase.
  typedef enum logic [2:0] {
    PH_IDLE,
    PH_WAIT,
    PH_HIGH,
    PH_LOW,
    PH_EXTRA,
    PH_GAP
  } phase_t;

  // Sequencer states for processing one tick.
  typedef enum logic [2:0] {
    C_IDLE,
    C_STEP,
    C_MUL,
    C_DIV,
    C_EMIT
  } ctl_state_t;

  typedef struct packed {
    logic    dout;
    opcode_t opcode;
  } in_item_t;

  typedef struct packed {
    logic                       sck;
    logic                       busy_res;
    logic                       done_res;
    logic                       error;
    logic signed [WEIGHT_W-1:0] weight;
    logic signed [RAW_W-1:0]    raw_value;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic step;
    logic mul;
    logic load_out;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic need_mul;
    logic need_div;
    logic div_done;
  } dp_stat_t;

endpackage

### sv/lcar_chan_if.sv
interface lcar_chan_if #(
  parameter type T = logic
) ();

  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);

endinterface

### sv/load_cell_adc_reader.sv
// Load-cell converter reader for a two-wire clock/data bridge ADC.
// Every input transfer on in_chan is one microsecond tick: the sampled data
// line and an opcode (none, weigh or tare). Every tick produces exactly one
// output transfer on out_chan with the clock level to drive next, busy, done,
// error, the saturated weight and the raw or averaged sample.
// Configuration (weight factor, tare average count, timeout and gap ticks)
// is written through cfg_we / cfg_index / cfg_wdata; the user must write it
// only while the block is idle, which the block does not enforce. A tick is
// captured in C_IDLE, worked in C_STEP, and its result is loaded into the
// output register in C_EMIT and offered from there. The tick that ends a
// good weigh passes C_MUL for the 25x32 multiplier; the tick that ends a
// tare with good reads waits in C_DIV for the bit-serial divider that forms
// the average. One tick is processed at a time; a new one is taken only
// after the last result is loaded. If the receiver stalls, the finished result
// waits in the output register; the next tick is still accepted and worked,
// and its result waits for the register to empty. Synchronous reset returns
// the protocol to idle, clears the tare offset and reloads config defaults.
module load_cell_adc_reader #(
  parameter int SAMPLE_BITS = 24
) (
  input  logic                                clk,
  input  logic                                rst_n,
  lcar_chan_if.sink                           in_chan,
  lcar_chan_if.source                         out_chan,
  input  logic                                cfg_we,
  input  logic [lcar_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [lcar_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  lcar_pkg::dp_cmd_t   cmd;
  lcar_pkg::dp_stat_t  stat;
  lcar_pkg::out_item_t out_item;
  logic                in_ready;
  logic                out_valid;

  // Sequencer for one tick.
  lcar_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_chan.ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  // Protocol state, arithmetic and output register.
  lcar_dp #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .in_item   (in_chan.data),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  assign in_chan.ready  = in_ready;
  assign out_chan.valid = out_valid;
  assign out_chan.data  = out_item;

endmodule

### sv/lcar_div.sv
module lcar_div (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic signed [lcar_pkg::SUM_W-1:0]   dividend,
  input  logic        [lcar_pkg::COUNT_W-1:0] divisor,
  output logic                                done,
  output logic signed [lcar_pkg::RAW_W-1:0]   quot
);

  localparam int SumW = lcar_pkg::SUM_W;
  localparam int CntW = lcar_pkg::COUNT_W;
  localparam int IterW = $clog2(SumW);

  logic             busy_r;
  logic [IterW-1:0] iter_r;
  logic             neg_r;
  logic [CntW-1:0]  dsr_r;
  logic [CntW-1:0]  rem_r;
  logic [SumW-1:0]  work_r;

  logic [CntW:0]    trial;
  logic [CntW:0]    trial_sub;
  logic             fits;
  logic [CntW-1:0]  rem_nxt;
  logic [SumW-1:0]  work_nxt;
  logic [SumW-1:0]  mag;
  logic [SumW-1:0]  signed_q;

  // One restoring step: one quotient bit per cycle, MSB first.
  always_comb begin
    trial     = {rem_r, work_r[SumW-1]};
    trial_sub = trial - {1'b0, dsr_r};
    fits      = (trial >= {1'b0, dsr_r});
    rem_nxt   = fits ? trial_sub[CntW-1:0] : trial[CntW-1:0];
    work_nxt  = {work_r[SumW-2:0], fits};
    signed_q  = neg_r ? (~work_nxt + SumW'(1)) : work_nxt;
    mag       = dividend[SumW-1] ? (~dividend + SumW'(1)) : dividend;
  end

  // The quotient truncates toward zero; the average always fits the raw width.
  assign done = busy_r && (iter_r == IterW'(SumW - 1));
  assign quot = signed_q[lcar_pkg::RAW_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (start) begin
      busy_r <= 1'b1;
    end else if (done) begin
      busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      iter_r <= '0;
      neg_r  <= dividend[SumW-1];
      dsr_r  <= divisor;
      rem_r  <= '0;
      work_r <= mag;
    end else if (busy_r) begin
      iter_r <= iter_r + IterW'(1);
      rem_r  <= rem_nxt;
      work_r <= work_nxt;
    end
  end

endmodule

### sv/lcar_dp.sv
module lcar_dp #(
  parameter int SAMPLE_BITS = 24
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  lcar_pkg::dp_cmd_t                      cmd,
  output lcar_pkg::dp_stat_t                     stat,
  input  lcar_pkg::in_item_t                     in_item,
  output lcar_pkg::out_item_t                    out_item,
  input  logic                                   cfg_we,
  input  logic [lcar_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [lcar_pkg::CFG_DATA_W-1:0]        cfg_wdata
);

  localparam int RawW   = lcar_pkg::RAW_W;
  localparam int SumW   = lcar_pkg::SUM_W;
  localparam int CntW   = lcar_pkg::COUNT_W;
  localparam int GapW   = lcar_pkg::GAP_W;
  localparam int DiffW  = lcar_pkg::DIFF_W;
  localparam int ProdW  = lcar_pkg::PROD_W;
  localparam int WgtW   = lcar_pkg::WEIGHT_W;
  localparam int QW     = ProdW - lcar_pkg::FRAC_BITS;
  localparam int PulseW = $clog2(SAMPLE_BITS + 1);

  // Configuration registers.
  logic signed [lcar_pkg::FACTOR_W-1:0]  wf_r;
  logic        [CntW-1:0]                avg_r;
  logic        [lcar_pkg::TIMEOUT_W-1:0] timeout_r;
  logic        [GapW-1:0]                gap_r;

  // Captured tick.
  logic                dout_r;
  lcar_pkg::opcode_t   opin_r;

  // Protocol state.
  lcar_pkg::phase_t        phase_r, phase_nxt;
  lcar_pkg::opcode_t       op_r, op_nxt;
  logic [PulseW-1:0]       pulse_r, pulse_nxt;
  logic [SAMPLE_BITS-1:0]  shift_r, shift_nxt;
  logic [GapW-1:0]         wait_r, wait_nxt;
  logic signed [SumW-1:0]  sum_r, sum_nxt;
  logic [CntW-1:0]         nvalid_r, nvalid_nxt;
  logic [CntW-1:0]         ndone_r, ndone_nxt;
  logic signed [RawW-1:0]  offset_r;

  // Result under construction.
  logic                    p_sck_r, p_done_r, p_err_r, p_mul_r;
  logic signed [RawW-1:0]  p_raw_r;
  logic signed [DiffW-1:0] mul_a_r;
  logic signed [ProdW-1:0] prod_r;
  lcar_pkg::out_item_t     out_r;

  // Step decisions.
  logic                    s_sck, s_done, s_err, s_mul, s_div;
  logic signed [RawW-1:0]  s_raw;
  logic                    re_fire, re_ok;
  logic signed [RawW-1:0]  re_val;
  logic signed [RawW-1:0]  sample;
  logic signed [DiffW-1:0] diff;
  logic [GapW-1:0]         wait_inc;
  logic [CntW-1:0]         need;

  logic                    div_done;
  logic signed [RawW-1:0]  div_q;
  logic signed [QW-1:0]    wq;
  logic signed [WgtW-1:0]  wsat;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wf_r      <= lcar_pkg::WEIGHT_FACTOR_RST;
      avg_r     <= lcar_pkg::AVERAGE_COUNT_RST;
      timeout_r <= lcar_pkg::TIMEOUT_TICKS_RST;
      gap_r     <= lcar_pkg::GAP_TICKS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        lcar_pkg::CFG_WEIGHT_FACTOR: wf_r      <= cfg_wdata;
        lcar_pkg::CFG_AVERAGE_COUNT: avg_r     <= cfg_wdata[CntW-1:0];
        lcar_pkg::CFG_TIMEOUT_TICKS: timeout_r <= cfg_wdata[lcar_pkg::TIMEOUT_W-1:0];
        lcar_pkg::CFG_GAP_TICKS:     gap_r     <= cfg_wdata[GapW-1:0];
        default: ;
      endcase
    end
  end

  // The sampled word, sign-extended to the raw width.
  assign sample   = RawW'($signed(shift_r));
  assign wait_inc = wait_r + GapW'(1);
  assign need     = (avg_r == '0) ? CntW'(1) : avg_r;
  assign diff     = DiffW'(re_val) - DiffW'(offset_r);

  // One tick of the converter protocol.
  always_comb begin
    phase_nxt  = phase_r;
    op_nxt     = op_r;
    pulse_nxt  = pulse_r;
    shift_nxt  = shift_r;
    wait_nxt   = wait_r;
    sum_nxt    = sum_r;
    nvalid_nxt = nvalid_r;
    ndone_nxt  = ndone_r;
    s_sck      = 1'b0;
    s_done     = 1'b0;
    s_err      = 1'b0;
    s_mul      = 1'b0;
    s_div      = 1'b0;
    s_raw      = '0;
    re_fire    = 1'b0;
    re_ok      = 1'b0;
    re_val     = '0;

    case (phase_r)
      lcar_pkg::PH_IDLE: begin
        if (opin_r == lcar_pkg::OP_WEIGH || opin_r == lcar_pkg::OP_TARE) begin
          op_nxt     = opin_r;
          sum_nxt    = '0;
          nvalid_nxt = '0;
          ndone_nxt  = '0;
          phase_nxt  = lcar_pkg::PH_WAIT;
          wait_nxt   = '0;
          pulse_nxt  = '0;
          shift_nxt  = '0;
        end
      end
      lcar_pkg::PH_WAIT: begin
        if (!dout_r) begin
          pulse_nxt = '0;
          shift_nxt = '0;
          s_sck     = 1'b1;
          phase_nxt = lcar_pkg::PH_HIGH;
        end else begin
          wait_nxt = wait_inc;
          if (wait_inc >= GapW'(timeout_r)) begin
            re_fire = 1'b1;
          end
        end
      end
      lcar_pkg::PH_HIGH: begin
        shift_nxt = {shift_r[SAMPLE_BITS-2:0], dout_r};
        pulse_nxt = pulse_r + PulseW'(1);
        phase_nxt = lcar_pkg::PH_LOW;
      end
      lcar_pkg::PH_LOW: begin
        s_sck     = 1'b1;
        phase_nxt = (pulse_r >= PulseW'(SAMPLE_BITS)) ? lcar_pkg::PH_EXTRA
                                                      : lcar_pkg::PH_HIGH;
      end
      lcar_pkg::PH_EXTRA: begin
        re_fire = 1'b1;
        re_ok   = 1'b1;
        re_val  = sample;
      end
      lcar_pkg::PH_GAP: begin
        if (wait_r >= gap_r) begin
          if (ndone_r >= need) begin
            // Tare complete: average if any read was good.
            s_done    = 1'b1;
            s_err     = (nvalid_r == '0);
            s_div     = (nvalid_r != '0);
            phase_nxt = lcar_pkg::PH_IDLE;
            op_nxt    = lcar_pkg::OP_NONE;
          end else begin
            phase_nxt = lcar_pkg::PH_WAIT;
            wait_nxt  = '0;
            pulse_nxt = '0;
            shift_nxt = '0;
          end
        end else begin
          wait_nxt = wait_inc;
        end
      end
      default: begin
        phase_nxt = lcar_pkg::PH_IDLE;
        op_nxt    = lcar_pkg::OP_NONE;
      end
    endcase

    // End of one conversion, good or timed out.
    if (re_fire) begin
      if (op_r == lcar_pkg::OP_WEIGH) begin
        s_done    = 1'b1;
        s_err     = !re_ok;
        s_mul     = re_ok;
        s_raw     = re_ok ? re_val : '0;
        phase_nxt = lcar_pkg::PH_IDLE;
        op_nxt    = lcar_pkg::OP_NONE;
      end else begin
        if (re_ok) begin
          sum_nxt    = sum_r + SumW'(re_val);
          nvalid_nxt = nvalid_r + CntW'(1);
        end
        ndone_nxt = ndone_r + CntW'(1);
        phase_nxt = lcar_pkg::PH_GAP;
        wait_nxt  = '0;
      end
    end
  end

  assign stat.need_mul = s_mul;
  assign stat.need_div = s_div;
  assign stat.div_done = div_done;

  // Divider for the tare average.
  lcar_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.step && s_div),
    .dividend (sum_r),
    .divisor  (nvalid_r),
    .done     (div_done),
    .quot     (div_q)
  );

  // Protocol state and tare offset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= lcar_pkg::PH_IDLE;
      op_r     <= lcar_pkg::OP_NONE;
      pulse_r  <= '0;
      shift_r  <= '0;
      wait_r   <= '0;
      sum_r    <= '0;
      nvalid_r <= '0;
      ndone_r  <= '0;
      offset_r <= '0;
    end else begin
      if (cmd.step) begin
        phase_r  <= phase_nxt;
        op_r     <= op_nxt;
        pulse_r  <= pulse_nxt;
        shift_r  <= shift_nxt;
        wait_r   <= wait_nxt;
        sum_r    <= sum_nxt;
        nvalid_r <= nvalid_nxt;
        ndone_r  <= ndone_nxt;
      end
      if (div_done) begin
        offset_r <= div_q;
      end
    end
  end

  // Tick capture, pending result fields and the product.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      dout_r <= in_item.dout;
      opin_r <= in_item.opcode;
    end
    if (cmd.step) begin
      p_sck_r  <= s_sck;
      p_done_r <= s_done;
      p_err_r  <= s_err;
      p_mul_r  <= s_mul;
      p_raw_r  <= s_raw;
      mul_a_r  <= diff;
    end else if (div_done) begin
      p_raw_r <= div_q;
    end
    if (cmd.mul) begin
      prod_r <= ProdW'(mul_a_r) * ProdW'(wf_r);
    end
    if (cmd.load_out) begin
      out_r <= '{sck:       p_sck_r,
                 busy_res:  (phase_r != lcar_pkg::PH_IDLE),
                 done_res:  p_done_r,
                 error:     p_err_r,
                 weight:    p_mul_r ? wsat : '0,
                 raw_value: p_raw_r};
    end
  end

  // Floor shift of the Q41.16 product, then saturation to 16 bits.
  always_comb begin
    wq = prod_r[ProdW-1:lcar_pkg::FRAC_BITS];
    if (wq > QW'(signed'(32767))) begin
      wsat = WgtW'(signed'(32767));
    end else if (wq < QW'(signed'(-32768))) begin
      wsat = WgtW'(signed'(-32768));
    end else begin
      wsat = wq[WgtW-1:0];
    end
  end

  assign out_item = out_r;

endmodule

### sv/lcar_ctrl.sv
module lcar_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  output lcar_pkg::dp_cmd_t   cmd,
  input  lcar_pkg::dp_stat_t  stat
);

  lcar_pkg::ctl_state_t state_r, state_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic                 emit;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      lcar_pkg::C_IDLE: begin
        if (in_valid) begin
          state_nxt = lcar_pkg::C_STEP;
        end
      end
      lcar_pkg::C_STEP: begin
        if (stat.need_mul) begin
          state_nxt = lcar_pkg::C_MUL;
        end else if (stat.need_div) begin
          state_nxt = lcar_pkg::C_DIV;
        end else begin
          state_nxt = lcar_pkg::C_EMIT;
        end
      end
      lcar_pkg::C_MUL: state_nxt = lcar_pkg::C_EMIT;
      lcar_pkg::C_DIV: begin
        if (stat.div_done) begin
          state_nxt = lcar_pkg::C_EMIT;
        end
      end
      lcar_pkg::C_EMIT: begin
        if (emit) begin
          state_nxt = lcar_pkg::C_IDLE;
        end
      end
      default: state_nxt = lcar_pkg::C_IDLE;
    endcase
  end

  // Commands and handshake outputs.
  always_comb begin
    emit         = (state_r == lcar_pkg::C_EMIT) && (!out_valid_r || out_ready);
    in_ready     = (state_r == lcar_pkg::C_IDLE);
    cmd.capture  = in_valid && (state_r == lcar_pkg::C_IDLE);
    cmd.step     = (state_r == lcar_pkg::C_STEP);
    cmd.mul      = (state_r == lcar_pkg::C_MUL);
    cmd.load_out = emit;
  end

  // The output register holds its result until the receiver takes it.
  always_comb begin
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lcar_pkg::C_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

### sv/lcar_checker.sv
module lcar_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input lcar_pkg::out_item_t out_data
);

  // A result stays offered until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result withdrawn before transfer");

  // One tick is worked at a time.
  a_one_tick: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n && in_valid && in_ready |=> !in_ready)
    else $error("second tick taken while one is in work");

  // An error is only reported with a finished operation.
  a_err_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (!out_data.error || out_data.done_res))
    else $error("error without done");

  // A nonzero weight only comes from a successful weigh.
  a_weight_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.weight != '0) |-> out_data.done_res && !out_data.error)
    else $error("weight outside a successful weigh");

  // A finished operation leaves the clock low and the block idle.
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.done_res |-> !out_data.sck && !out_data.busy_res)
    else $error("done while clocking or busy");

endmodule

bind load_cell_adc_reader lcar_checker u_lcar_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_chan.valid),
  .in_ready  (in_chan.ready),
  .out_valid (out_chan.valid),
  .out_ready (out_chan.ready),
  .out_data  (out_chan.data)
);
